// File: src/pbsq_pkg.sv
`default_nettype none

package pbsq_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_BASE_FREQ = 2'd0;
    localparam logic [1:0] REG_STEP_PER_HZ = 2'd1;
    localparam logic [1:0] REG_FM_ENABLE = 2'd2;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    // Field widths
    localparam int BASE_W = 24;
    localparam int FM_W = 24;
    localparam int STEP_W = 32;
    // Clamped frequency fits in 25 unsigned bits
    localparam int FREQ_W = 25;
    // Full frequency times step product
    localparam int PROD_W = FREQ_W + STEP_W;
    // The product carries 48 fraction bits of a cycle
    localparam int PROD_FRAC = 48;

    // Ratio 1 - t/dt resolution and its width including the value one
    localparam int RATIO_BITS = 24;
    localparam int R_W = RATIO_BITS + 1;
    localparam int SQ_W = 2 * R_W;

    // 0.707 in Q16, held as a positive signed constant
    localparam int GAIN_W = 17;
    localparam logic signed [GAIN_W-1:0] GAIN_Q16 = 17'sd46334;
    localparam int GAIN_SHIFT = 16;

    // Register reset values
    localparam logic [BASE_W-1:0] BASE_FREQ_RST = 24'd113280;
    localparam logic [STEP_W-1:0] STEP_RST = 32'd22906492;

    // Step counter wide enough for the longest serial pass
    localparam int CNT_W = 5;

endpackage

`default_nettype wire

// File: src/pbsq_if.sv
`default_nettype none

// Input channel: one word per output sample
interface pbsq_fm_if;
    logic                              valid;
    logic                              ready;
    logic signed [pbsq_pkg::FM_W-1:0]  fm_offset;
    logic                              block_end;

    modport source (output valid, output fm_offset, output block_end, input ready);
    modport sink (input valid, input fm_offset, input block_end, output ready);
endinterface

// Output channel: one saturated sample per word
interface pbsq_wave_if #(
    parameter int OUT_BITS = 16
);
    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] sample;
    logic                       frame_last;

    modport source (output valid, output sample, output frame_last, input ready);
    modport sink (input valid, input sample, input frame_last, output ready);
endinterface

`default_nettype wire

// File: src/polyblep_square_oscillator.sv
`default_nettype none

// Band-limited square oscillator. Each word on the fm channel yields one
// sample word on the wave channel, in signed Q2.(OUT_BITS-2). A new word is
// taken only once the previous sample has been loaded into the output register.
// The bit-serial datapath works in steps: the shift-add multiply of frequency by
// step (one frequency bit per cycle), edge set-up in the compare and subtract
// states, restoring division for the ratios 1 - t/dt of both edges side by side,
// shift-add squaring of both ratios, and then the sum, the 0.707 gain and
// saturation. The result sits in an output register, so the next word is worked
// on while the previous sample waits to be taken.
// Configuration is to be written through cfg_we, cfg_index and cfg_data while the
// block is idle; the block itself does not enforce this. An unknown index is ignored.
module polyblep_square_oscillator #(
    parameter int PHASE_BITS = 32,
    parameter int OUT_BITS = 16
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_we,
    input  wire [pbsq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [pbsq_pkg::CFG_DATA_W-1:0]     cfg_data,
    pbsq_fm_if.sink                            fm,
    pbsq_wave_if.source                        wave
);
    import pbsq_pkg::*;

    localparam int DT_SHIFT = PROD_FRAC - PHASE_BITS;
    localparam int DT_W = PROD_W - DT_SHIFT;
    localparam int FRAC = OUT_BITS - 2;
    localparam int SQ_SHIFT = 2 * RATIO_BITS - FRAC;
    localparam int CORR_W = FRAC + 1;
    localparam int SUM_W = FRAC + 3;
    localparam int PRODS_W = SUM_W + GAIN_W;
    localparam int SH_W = PRODS_W - GAIN_SHIFT;

    localparam logic [PHASE_BITS-1:0] HALF = {1'b1, {(PHASE_BITS-1){1'b0}}};
    localparam logic [PHASE_BITS:0] CYCLE = {1'b1, {PHASE_BITS{1'b0}}};
    localparam logic [R_W-1:0] R_ONE = {1'b1, {RATIO_BITS{1'b0}}};
    localparam logic [SQ_W-1:0] SQ_RND = {{(SQ_W-1){1'b0}}, 1'b1} << (SQ_SHIFT - 1);
    localparam logic signed [SUM_W-1:0] RAW_POS = {3'b001, {FRAC{1'b0}}};
    localparam logic signed [PRODS_W-1:0] GAIN_RND =
        {{(PRODS_W-GAIN_SHIFT){1'b0}}, 1'b1, {(GAIN_SHIFT-1){1'b0}}};
    localparam logic signed [SH_W-1:0] SAT_HI =
        {{(SH_W-OUT_BITS+1){1'b0}}, {(OUT_BITS-1){1'b1}}};
    localparam logic signed [SH_W-1:0] SAT_LO =
        {{(SH_W-OUT_BITS+1){1'b1}}, {(OUT_BITS-1){1'b0}}};

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_CMP   = 4'd2;
    localparam logic [3:0] S_SUB   = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_SQR   = 4'd5;
    localparam logic [3:0] S_SUM   = 4'd6;
    localparam logic [3:0] S_SCALE = 4'd7;
    localparam logic [3:0] S_SAT   = 4'd8;

    // Control state
    logic [3:0]            state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  out_valid_reg, out_valid_next;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic [BASE_W-1:0]     base_freq_reg;
    logic [STEP_W-1:0]     step_reg;
    logic                  fm_en_reg;

    // Datapath registers
    logic [STEP_W-1:0]          mul_hi_reg, mul_hi_next;
    logic [FREQ_W-1:0]          mul_lo_reg, mul_lo_next;
    logic                       last_reg, last_next;
    logic [PHASE_BITS:0]        tsel_reg [2];
    logic [PHASE_BITS:0]        tsel_next [2];
    logic [1:0]                 act_reg, act_next;
    logic [1:0]                 neg_reg, neg_next;
    logic [1:0]                 sat_reg, sat_next;
    logic [DT_W-1:0]            rem_reg [2];
    logic [DT_W-1:0]            rem_next [2];
    logic [R_W-1:0]             q_reg [2];
    logic [R_W-1:0]             q_next [2];
    logic [R_W-1:0]             sq_hi_reg [2];
    logic [R_W-1:0]             sq_hi_next [2];
    logic [R_W-1:0]             sq_lo_reg [2];
    logic [R_W-1:0]             sq_lo_next [2];
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic signed [PRODS_W-1:0]  prods_reg, prods_next;
    logic signed [OUT_BITS-1:0] sample_reg, sample_next;
    logic                       frame_last_reg, frame_last_next;

    // Combinational helpers
    logic signed [FREQ_W:0]  freq_sum;
    logic [FREQ_W-1:0]       freq;
    logic [STEP_W:0]         mul_sum;
    logic [PROD_W-1:0]       prod;
    logic [DT_W-1:0]         dt;
    logic [PHASE_BITS-1:0]   t_lane [2];
    logic [PHASE_BITS:0]     u_lane [2];
    logic [1:0]              after_lane, before_lane;
    logic [DT_W:0]           rem2 [2];
    logic [DT_W:0]           rem_diff [2];
    logic [1:0]              ge_lane;
    logic [R_W-1:0]          q_fin [2];
    logic [R_W:0]            sq_sum [2];
    logic [SQ_W-1:0]         sq_rnd [2];
    logic signed [SUM_W-1:0] corr_s [2];
    logic signed [SUM_W-1:0] blep [2];
    logic signed [SUM_W-1:0] raw;
    logic signed [SH_W-1:0]  scaled;
    logic                    out_load;

    // Instantaneous frequency, clamped at zero
    always_comb
    begin
        freq_sum = $signed({2'b00, base_freq_reg});
        if (fm_en_reg)
        begin
            freq_sum = freq_sum + (FREQ_W+1)'(fm.fm_offset);
        end
        freq = freq_sum[FREQ_W] ? '0 : freq_sum[FREQ_W-1:0];
    end

    // Phase step from the serial product
    assign mul_sum = {1'b0, mul_hi_reg} + (mul_lo_reg[0] ? {1'b0, step_reg} : '0);
    assign prod = {mul_hi_reg, mul_lo_reg};
    assign dt = prod[PROD_W-1:DT_SHIFT];

    // Per-edge lane logic: lane 0 is the rising edge, lane 1 the falling edge
    always_comb
    begin
        t_lane[0] = phase_reg;
        t_lane[1] = phase_reg + HALF;
        for (int l = 0; l < 2; l++)
        begin
            u_lane[l] = CYCLE - {1'b0, t_lane[l]};
            after_lane[l] = DT_W'(t_lane[l]) < dt;
            before_lane[l] = DT_W'(u_lane[l]) < dt;
            rem2[l] = {rem_reg[l], 1'b0};
            rem_diff[l] = rem2[l] - {1'b0, dt};
            ge_lane[l] = rem2[l] >= {1'b0, dt};
            q_fin[l] = sat_reg[l] ? R_ONE : {q_reg[l][R_W-2:0], ge_lane[l]};
            sq_sum[l] = {1'b0, sq_hi_reg[l]} + (sq_lo_reg[l][0] ? {1'b0, q_reg[l]} : '0);
            sq_rnd[l] = {sq_hi_reg[l], sq_lo_reg[l]} + SQ_RND;
            corr_s[l] = $signed({2'b00, sq_rnd[l][SQ_SHIFT+CORR_W-1:SQ_SHIFT]});
            if (!act_reg[l])
            begin
                blep[l] = '0;
            end
            else if (neg_reg[l])
            begin
                blep[l] = -corr_s[l];
            end
            else
            begin
                blep[l] = corr_s[l];
            end
        end
        raw = phase_reg[PHASE_BITS-1] ? -RAW_POS : RAW_POS;
    end

    assign scaled = prods_reg[PRODS_W-1:GAIN_SHIFT];
    assign out_load = (state_reg == S_SAT) && (!out_valid_reg || wave.ready);

    // Sequencer and datapath next values
    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        phase_next = phase_reg;
        mul_hi_next = mul_hi_reg;
        mul_lo_next = mul_lo_reg;
        last_next = last_reg;
        act_next = act_reg;
        neg_next = neg_reg;
        sat_next = sat_reg;
        sum_next = sum_reg;
        prods_next = prods_reg;
        sample_next = sample_reg;
        frame_last_next = frame_last_reg;
        for (int l = 0; l < 2; l++)
        begin
            tsel_next[l] = tsel_reg[l];
            rem_next[l] = rem_reg[l];
            q_next[l] = q_reg[l];
            sq_hi_next[l] = sq_hi_reg[l];
            sq_lo_next[l] = sq_lo_reg[l];
        end

        case (state_reg)
            S_IDLE:
            begin
                if (fm.valid)
                begin
                    mul_hi_next = '0;
                    mul_lo_next = freq;
                    last_next = fm.block_end;
                    cnt_next = CNT_W'(FREQ_W - 1);
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                mul_hi_next = mul_sum[STEP_W:1];
                mul_lo_next = {mul_sum[0], mul_lo_reg[FREQ_W-1:1]};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                // Pick the distance to the edge, after it taking priority
                for (int l = 0; l < 2; l++)
                begin
                    tsel_next[l] = after_lane[l] ? {1'b0, t_lane[l]} : u_lane[l];
                    act_next[l] = after_lane[l] || before_lane[l];
                    neg_next[l] = after_lane[l];
                end
                state_next = S_SUB;
            end
            S_SUB:
            begin
                for (int l = 0; l < 2; l++)
                begin
                    rem_next[l] = dt - DT_W'(tsel_reg[l]);
                    sat_next[l] = tsel_reg[l] == '0;
                    q_next[l] = '0;
                end
                cnt_next = CNT_W'(RATIO_BITS - 1);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // One quotient bit per cycle on both lanes
                for (int l = 0; l < 2; l++)
                begin
                    rem_next[l] = ge_lane[l] ? rem_diff[l][DT_W-1:0] : rem2[l][DT_W-1:0];
                    q_next[l] = {q_reg[l][R_W-2:0], ge_lane[l]};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    for (int l = 0; l < 2; l++)
                    begin
                        q_next[l] = q_fin[l];
                        sq_hi_next[l] = '0;
                        sq_lo_next[l] = q_fin[l];
                    end
                    cnt_next = CNT_W'(R_W - 1);
                    state_next = S_SQR;
                end
            end
            S_SQR:
            begin
                for (int l = 0; l < 2; l++)
                begin
                    sq_hi_next[l] = sq_sum[l][R_W:1];
                    sq_lo_next[l] = {sq_sum[l][0], sq_lo_reg[l][R_W-1:1]};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                sum_next = raw + blep[0] - blep[1];
                phase_next = phase_reg + dt[PHASE_BITS-1:0];
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                prods_next = sum_reg * GAIN_Q16 + GAIN_RND;
                state_next = S_SAT;
            end
            S_SAT:
            begin
                if (out_load)
                begin
                    if (scaled > SAT_HI)
                    begin
                        sample_next = SAT_HI[OUT_BITS-1:0];
                    end
                    else if (scaled < SAT_LO)
                    begin
                        sample_next = SAT_LO[OUT_BITS-1:0];
                    end
                    else
                    begin
                        sample_next = scaled[OUT_BITS-1:0];
                    end
                    frame_last_next = last_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Output register empties when taken and fills from the last step
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (wave.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
            phase_reg <= '0;
            base_freq_reg <= BASE_FREQ_RST;
            step_reg <= STEP_RST;
            fm_en_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            out_valid_reg <= out_valid_next;
            phase_reg <= phase_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BASE_FREQ:   base_freq_reg <= cfg_data[BASE_W-1:0];
                    REG_STEP_PER_HZ: step_reg <= cfg_data[STEP_W-1:0];
                    REG_FM_ENABLE:   fm_en_reg <= cfg_data[0];
                    default:         ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        mul_hi_reg <= mul_hi_next;
        mul_lo_reg <= mul_lo_next;
        last_reg <= last_next;
        act_reg <= act_next;
        neg_reg <= neg_next;
        sat_reg <= sat_next;
        sum_reg <= sum_next;
        prods_reg <= prods_next;
        sample_reg <= sample_next;
        frame_last_reg <= frame_last_next;
        for (int l = 0; l < 2; l++)
        begin
            tsel_reg[l] <= tsel_next[l];
            rem_reg[l] <= rem_next[l];
            q_reg[l] <= q_next[l];
            sq_hi_reg[l] <= sq_hi_next[l];
            sq_lo_reg[l] <= sq_lo_next[l];
        end
    end

    // Channel outputs
    assign fm.ready = state_reg == S_IDLE;
    assign wave.valid = out_valid_reg;
    assign wave.sample = sample_reg;
    assign wave.frame_last = frame_last_reg;

endmodule

`default_nettype wire

// File: src/pbsq_checker.sv
`default_nettype none

module pbsq_checker #(
    parameter int OUT_BITS = 16
) (
    input wire                clk,
    input wire                rst_n,
    input wire                in_valid,
    input wire                in_ready,
    input wire                out_valid,
    input wire                out_ready,
    input wire [OUT_BITS-1:0] sample,
    input wire                frame_last
);

    // A stalled sample word holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample) && $stable(frame_last))
        else $error("stalled output word changed");

    // Only one word is worked on at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a word is in progress");

    // A result never appears in the cycle after its word is taken
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("output appeared too soon after input");

endmodule

bind polyblep_square_oscillator pbsq_checker #(
    .OUT_BITS(OUT_BITS)
) u_pbsq_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(fm.valid),
    .in_ready(fm.ready),
    .out_valid(wave.valid),
    .out_ready(wave.ready),
    .sample(wave.sample),
    .frame_last(wave.frame_last)
);

`default_nettype wire
